### sv/aes_cbc_mac_stream_defines.svh
// Assertion helpers for the CBC-MAC block.
`ifndef AES_CBC_MAC_STREAM_DEFINES_SVH
`define AES_CBC_MAC_STREAM_DEFINES_SVH
`define ACM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ACM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`endif

### sv/acm_pkg.sv
`timescale 1ns / 1ps
package acm_pkg;
  localparam int unsigned BlockW = 128;
  localparam int unsigned KeyW   = 64;
  localparam int unsigned QDepth = 4;

  typedef enum logic [0:0] {
    CfgKeyHigh = 1'b0,
    CfgKeyLow  = 1'b1
  } cfg_idx_e;

  // one absorb job for the back end
  typedef struct packed {
    logic [7:0]  octet;
    logic [3:0]  pos;      // fill position of octet
    logic        enc;      // block full after this octet / length octets
    logic        len_add;  // also absorb two length octets
    logic [15:0] len;
    logic        last;
    logic        pad_enc;  // last with partial block: encrypt once more
    logic        short_hdr;
    logic        first;    // clear chain before absorbing
  } job_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // state octet i sits in bits [127-8i -: 8]
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic fin);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[4*c+j] = sbox(s[127 - 8*(4*((c+j)%4)+j) -: 8]);
      end
    end
    if (!fin) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[127 - 8*i -: 8] = t[i];
    end
    return o ^ rk;
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, g;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    g  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ g; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction
endpackage

### sv/acm_front.sv
`timescale 1ns / 1ps
module acm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      octet_i,
  input  logic [15:0]     ad_length_i,
  input  logic            last_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output acm_pkg::job_t   job_o
);
  import acm_pkg::*;

  logic        in_msg_q, in_msg_d;
  logic [3:0]  fill_q, fill_d;
  logic [4:0]  hdr_q, hdr_d;
  logic [15:0] len_q;
  logic        acc;
  logic [3:0]  f0;
  logic [4:0]  h0, h1;
  logic        len_add;
  logic [3:0]  f1;

  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign acc         = in_valid_i && in_ready_o;

  always_comb begin
    f0      = in_msg_q ? fill_q : 4'd0;
    h0      = in_msg_q ? hdr_q : 5'd0;
    len_add = (h0 == 5'd15);
    h1      = (h0 < 5'd16) ? h0 + 5'd1 : h0;
    f1      = f0 + (len_add ? 4'd3 : 4'd1);
    job_o.octet     = octet_i;
    job_o.pos       = f0;
    job_o.len_add   = len_add;
    job_o.len       = in_msg_q ? len_q : ad_length_i;
    job_o.enc       = len_add ? (f0 >= 4'd13) : (f0 == 4'd15);
    job_o.last      = last_i;
    job_o.pad_enc   = last_i && (f1 != 4'd0);
    job_o.short_hdr = h1 < 5'd16;
    job_o.first     = !in_msg_q;
    in_msg_d = in_msg_q;
    fill_d   = fill_q;
    hdr_d    = hdr_q;
    if (acc) begin
      in_msg_d = !last_i;
      fill_d   = f1;
      hdr_d    = h1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q <= 1'b0;
      fill_q   <= '0;
      hdr_q    <= '0;
    end else begin
      in_msg_q <= in_msg_d;
      fill_q   <= fill_d;
      hdr_q    <= hdr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && !in_msg_q) begin
      len_q <= ad_length_i;
    end
  end
endmodule

### sv/acm_queue.sv
`timescale 1ns / 1ps
`include "aes_cbc_mac_stream_defines.svh"
module acm_queue #(
  parameter int unsigned Depth = acm_pkg::QDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  acm_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output acm_pkg::job_t rd_data_o
);
  import acm_pkg::*;
  localparam int unsigned AW = $clog2(Depth);

  job_t mem [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          wr, rd;

  assign wr_ready_o = cnt_q != Depth[AW:0];
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + {{AW{1'b0}}, wr} - {{AW{1'b0}}, rd};
    end
  end

  `ACM_ASSERT(a_no_over, cnt_q <= Depth[AW:0], "queue count overflow")
  `ACM_ASSERT_NEXT(a_cnt_up, wr && !rd, cnt_q == $past(cnt_q) + 1'b1, "count did not rise")
  `ACM_ASSERT_NEXT(a_cnt_dn, rd && !wr, cnt_q == $past(cnt_q) - 1'b1, "count did not fall")
endmodule

### sv/acm_back.sv
`timescale 1ns / 1ps
`include "aes_cbc_mac_stream_defines.svh"
module acm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [127:0]   key_i,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  acm_pkg::job_t  job_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output logic [127:0]   res_mac_o,
  output logic           res_short_o
);
  import acm_pkg::*;

  typedef enum logic [3:0] {
    StAbs  = 4'b0001,
    StEnc1 = 4'b0010, // encrypt, then resume job remainder
    StEnc2 = 4'b0100, // final pad encrypt
    StOut  = 4'b1000
  } st_e;

  st_e          st_q, st_d;
  logic [127:0] cb_q, cb_d, rk_q, rk_d, base, xin;
  logic [3:0]   rnd_q, rnd_d;
  logic [7:0]   rc_q, rc_d;
  logic         rem_q, rem_d;   // length octets still owed after mid-job encrypt
  logic [3:0]   rpos_q, rpos_d;
  job_t         jb_q, jb_d;
  logic         take;
  logic         obusy_q, obusy_d;
  logic [127:0] omac_q, omac_d;
  logic         oshort_q, oshort_d;

  assign res_valid_o = obusy_q;
  assign res_mac_o   = omac_q;
  assign res_short_o = oshort_q;
  assign job_ready_o = (st_q == StAbs);
  assign take        = job_valid_i && job_ready_o;

  function automatic logic [127:0] put(input logic [127:0] b, input logic [3:0] p,
                                       input logic [7:0] v);
    logic [127:0] r;
    r = b;
    r[127 - 8*p -: 8] = r[127 - 8*p -: 8] ^ v;
    return r;
  endfunction

  always_comb begin
    st_d = st_q; cb_d = cb_q; rk_d = rk_q; rnd_d = rnd_q; rc_d = rc_q;
    rem_d = rem_q; rpos_d = rpos_q; jb_d = jb_q;
    obusy_d = obusy_q && !res_ready_i; omac_d = omac_q; oshort_d = oshort_q;
    base = '0; xin = '0;
    case (st_q)
      StAbs: begin
        if (take) begin
          jb_d = job_i;
          base = job_i.first ? '0 : cb_q;
          xin  = put(base, job_i.pos, job_i.octet);
          rem_d = 1'b0;
          if (job_i.len_add) begin
            if (job_i.pos == 4'd15) begin
              rem_d = 1'b1; rpos_d = 4'd0;
            end else begin
              xin = put(xin, job_i.pos + 4'd1, job_i.len[15:8]);
              if (job_i.pos == 4'd14) begin
                rem_d = 1'b1; rpos_d = 4'd15;
              end else begin
                xin = put(xin, job_i.pos + 4'd2, job_i.len[7:0]);
              end
            end
          end
          if (job_i.enc) begin
            cb_d = xin ^ key_i; rk_d = key_i; rnd_d = 4'd1; rc_d = 8'h01;
            st_d = StEnc1;
          end else if (job_i.pad_enc) begin
            cb_d = xin ^ key_i; rk_d = key_i; rnd_d = 4'd1; rc_d = 8'h01;
            st_d = StEnc2;
          end else begin
            cb_d = xin;
            if (job_i.last) st_d = StOut;
          end
        end
      end
      StEnc1, StEnc2: begin
        rk_d  = key_next(rk_q, rc_q);
        rc_d  = xt(rc_q);
        cb_d  = aes_round(cb_q, rk_d, rnd_q == 4'd10);
        rnd_d = rnd_q + 4'd1;
        if (rnd_q == 4'd10) begin
          st_d = StAbs;
          if (st_q == StEnc1) begin
            xin = cb_d;
            if (rem_q) begin
              if (rpos_q == 4'd0) begin
                xin = put(xin, 4'd0, jb_q.len[15:8]);
                xin = put(xin, 4'd1, jb_q.len[7:0]);
              end else begin
                xin = put(xin, 4'd0, jb_q.len[7:0]);
              end
              rem_d = 1'b0;
            end
            cb_d = xin;
            if (jb_q.last) begin
              if (rem_q) begin
                cb_d = xin ^ key_i; rk_d = key_i; rnd_d = 4'd1; rc_d = 8'h01;
                st_d = StEnc2;
              end else begin
                st_d = StOut;
              end
            end
          end else begin
            st_d = StOut;
          end
        end
      end
      StOut: begin
        if (!obusy_q || res_ready_i) begin
          obusy_d = 1'b1; omac_d = cb_q; oshort_d = jb_q.short_hdr;
          st_d = StAbs;
        end
      end
      default: st_d = StAbs;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StAbs; obusy_q <= 1'b0;
    end else begin
      st_q <= st_d; obusy_q <= obusy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cb_q <= cb_d; rk_q <= rk_d; rnd_q <= rnd_d; rc_q <= rc_d;
    rem_q <= rem_d; rpos_q <= rpos_d; jb_q <= jb_d;
    omac_q <= omac_d; oshort_q <= oshort_d;
  end

  `ACM_ASSERT(a_onehot, $onehot(st_q), "state not one-hot")
  `ACM_ASSERT_NEXT(a_hold, res_valid_o && !res_ready_i, res_valid_o && $stable(res_mac_o),
                   "result dropped")
  `ACM_ASSERT(a_take_abs, !take || st_q == StAbs, "job taken while busy")
endmodule

### sv/aes_cbc_mac_stream.sv
`timescale 1ns / 1ps
// AES-128 CBC-MAC over a stream of octets, one per word. The front end tracks
// fill and header position and takes a word every cycle while the job queue
// has room; the back end XORs octets into the chain block as it takes each
// job and runs a full block through a one-round-per-cycle AES core (key
// schedule computed alongside). A partial final block is also encrypted
// before the MAC word is offered. The four-entry queue holds words while the
// back end encrypts; once it is full the input stalls. A waiting MAC word
// only holds up the back end once the next message's MAC is ready. The MAC
// word has tdata = {mac_low, mac_high}, tuser = short_header. Key writes must
// only happen while idle.
module aes_cbc_mac_stream #(
  parameter int unsigned QueueDepth = acm_pkg::QDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,  // octet[7:0], ad_length[23:8]
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // mac_high[63:0], mac_low[127:64]
  output logic         m_axis_tuser,  // short_header
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [63:0]  cfg_data_i
);
  import acm_pkg::*;

  logic [KeyW-1:0] kh_q, kl_q;
  logic  fv, fr, bv, br;
  job_t  fj, bj;
  logic [127:0] mac;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kh_q <= '0; kl_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgKeyHigh: kh_q <= cfg_data_i;
        CfgKeyLow:  kl_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  acm_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .octet_i(s_axis_tdata[7:0]), .ad_length_i(s_axis_tdata[23:8]), .last_i(s_axis_tlast),
    .job_valid_o(fv), .job_ready_i(fr), .job_o(fj)
  );

  acm_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(fj),
    .rd_valid_o(bv), .rd_ready_i(br), .rd_data_o(bj)
  );

  acm_back u_back (
    .clk_i, .rst_ni, .key_i({kh_q, kl_q}),
    .job_valid_i(bv), .job_ready_o(br), .job_i(bj),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_mac_o(mac), .res_short_o(m_axis_tuser)
  );

  assign m_axis_tdata = {mac[63:0], mac[127:64]};
endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import acm_pkg::*;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        shrt;
  } mac_t;

  // predictor of the CBC-MAC; octet i of the chain sits in chain[127-8i -: 8]
  class mac_scoreboard;
    logic [63:0]  key_hi, key_lo;
    logic [127:0] chain;
    int unsigned  fill, hdr;
    logic [15:0]  len_held;
    bit           busy;
    mac_t         pending[$];
    int unsigned  errors;

    function void reset_state();
      key_hi = '0; key_lo = '0; chain = '0; fill = 0; hdr = 0;
      len_held = '0; busy = 0; errors = 0;
    endfunction

    function logic [7:0] sb(input logic [7:0] a);
      logic [7:0] inv, p, c;
      logic [7:0] r;
      inv = 8'h00;
      for (int x = 1; x < 256; x++) begin
        p = 8'h00; c = x[7:0];
        for (int k = 0; k < 8; k++) begin
          if (a[k]) p ^= c;
          c = {c[6:0], 1'b0} ^ (c[7] ? 8'h1b : 8'h00);
        end
        if (p == 8'h01) inv = x[7:0];
      end
      for (int k = 0; k < 8; k++)
        r[k] = inv[k] ^ inv[(k+4)%8] ^ inv[(k+5)%8] ^ inv[(k+6)%8] ^ inv[(k+7)%8];
      return r ^ 8'h63;
    endfunction

    function logic [7:0] dbl(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function void encrypt();
      logic [7:0] rk[176];
      logic [7:0] s[16], t[16], w[4], f, rc, a0, a1, a2, a3, al;
      rc = 8'h01;
      for (int i = 0; i < 8; i++) begin
        rk[i] = key_hi[63-8*i -: 8];
        rk[8+i] = key_lo[63-8*i -: 8];
      end
      for (int i = 16; i < 176; i += 4) begin
        for (int j = 0; j < 4; j++) w[j] = rk[i-4+j];
        if (i % 16 == 0) begin
          f = w[0];
          w[0] = sb(w[1]) ^ rc; w[1] = sb(w[2]); w[2] = sb(w[3]); w[3] = sb(f);
          rc = dbl(rc);
        end
        for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ w[j];
      end
      for (int i = 0; i < 16; i++) s[i] = chain[127-8*i -: 8] ^ rk[i];
      for (int r = 1; r <= 10; r++) begin
        for (int c = 0; c < 4; c++)
          for (int j = 0; j < 4; j++) t[4*c+j] = sb(s[4*((c+j)%4)+j]);
        if (r < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
            t[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
            t[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
            t[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
          end
        end
        for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r+i];
      end
      for (int i = 0; i < 16; i++) chain[127-8*i -: 8] = s[i];
    endfunction

    function void absorb(input logic [7:0] b);
      chain[127-8*fill -: 8] ^= b;
      fill = (fill + 1) % 16;
      if (fill == 0) encrypt();
    endfunction

    function void note_word(input logic [7:0] oc, input logic [15:0] len, input logic lst);
      mac_t m;
      if (!busy) begin
        chain = '0; fill = 0; hdr = 0; len_held = len; busy = 1;
      end
      absorb(oc);
      if (hdr < 16) begin
        hdr++;
        if (hdr == 16) begin
          absorb(len_held[15:8]);
          absorb(len_held[7:0]);
        end
      end
      if (lst) begin
        if (fill != 0) encrypt();
        m.hi = chain[127:64]; m.lo = chain[63:0]; m.shrt = (hdr < 16);
        pending.push_back(m);
        chain = '0; fill = 0; hdr = 0; busy = 0;
      end
    endfunction

    function void check_mac(input logic [127:0] data, input logic shrt);
      mac_t m;
      if (pending.size() == 0) begin
        $display("%0t: unexpected MAC %h", $time, data);
        errors++;
        return;
      end
      m = pending.pop_front();
      if (data[63:0] !== m.hi) begin
        $display("%0t: mac_high exp %h got %h", $time, m.hi, data[63:0]);
        errors++;
      end
      if (data[127:64] !== m.lo) begin
        $display("%0t: mac_low exp %h got %h", $time, m.lo, data[127:64]);
        errors++;
      end
      if (shrt !== m.shrt) begin
        $display("%0t: short_header exp %b got %b", $time, m.shrt, shrt);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata = '0;
  logic         s_axis_tlast = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid_i = 0;
  logic         cfg_ready_o;
  cfg_idx_e     cfg_index_i = CfgKeyHigh;
  logic [63:0]  cfg_data_i = '0;

  mac_scoreboard sb = new();
  bit stim_done = 0;
  bit hold_off = 0;

  aes_cbc_mac_stream dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  function int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_key(input cfg_idx_e idx, input logic [63:0] val);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgKeyHigh) sb.key_hi = val; else sb.key_lo = val;
    @(negedge clk_i);
    cfg_valid_i <= 0;
    @(negedge clk_i);
  endtask

  task automatic send_word(input logic [7:0] oc, input logic [15:0] len, input logic lst,
                           input bit gaps);
    int unsigned g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1; s_axis_tdata <= {len, oc}; s_axis_tlast <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(oc, len, lst);
    @(negedge clk_i);
  endtask

  task automatic send_msg(input int unsigned n, input bit gaps);
    for (int i = 0; i < n; i++)
      send_word(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), i == n - 1,
                gaps);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // receiver
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_mac(m_axis_tdata, m_axis_tuser);
  end
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 0;
    else if ($urandom_range(0, 9) < 3) m_axis_tready <= 0;
    else m_axis_tready <= 1;
  end

  initial begin
    int unsigned sent, n;
    sb.reset_state();
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: all-zero key, then extremes
    send_msg(1, 0);
    send_word(8'hff, 16'hffff, 1'b0, 0);
    for (int i = 1; i < 15; i++) send_word(8'h00, 16'h0000, 1'b0, 0);
    send_word(8'hff, 16'h0000, 1'b1, 0);
    drain();
    write_key(CfgKeyHigh, 64'hffff_ffff_ffff_ffff);
    write_key(CfgKeyLow, 64'hffff_ffff_ffff_ffff);
    send_word(8'h00, 16'h0000, 1'b0, 0);
    for (int i = 1; i < 32; i++) send_word(8'hff, 16'hffff, i == 31, 0);
    drain();
    write_key(CfgKeyHigh, 64'h2b7e1516_28aed2a6);
    write_key(CfgKeyLow, 64'habf71588_09cf4f3c);

    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      for (int k = 0; k < 10; k++) begin
        case ($urandom_range(0, 5))
          0: n = $urandom_range(1, 15);
          1: n = 16;
          2: n = $urandom_range(17, 30);
          default: n = $urandom_range(1, 60);
        endcase
        if (ph == 2 && k == 3) begin
          fork
            begin
              send_msg(n, 0);
              for (int j = 0; j < 8; j++) send_msg($urandom_range(1, 3), 0);
            end
            begin
              hold_off = 1;
              repeat (150) @(negedge clk_i);
              hold_off = 0;
            end
          join
        end else begin
          send_msg(n, 1);
        end
        sent += n;
      end
      drain();
      write_key(CfgKeyHigh, {$urandom, $urandom});
      write_key(CfgKeyLow, (ph == 4) ? 64'h0 : {$urandom, $urandom});
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    repeat (50) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
